### design/pn3d_pkg.sv
// ----------------------------------------------------------------------------
// pn3d_pkg
// Shared types, constants and arithmetic helpers for the 3D gradient noise
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pn3d_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = 8;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 24;
  localparam int OUT_W      = 18;
  localparam int Q_W        = 20;
  localparam int FADE_W     = 18;
  localparam int VAL_W      = 20;
  localparam int AXES       = 3;
  localparam int CORNERS    = 8;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sh20000;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_t;

  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [FRAC_BITS-1:0]        frac_t;
  typedef logic [FADE_W-1:0]           fade_t;
  typedef logic signed [VAL_W-1:0]     val_t;

  // dot product of the corner gradient with the offset vector
  function automatic val_t grad(input idx_t hash, input val_t x, input val_t y,
                                input val_t z);
    logic [3:0] h;
    val_t       gu;
    val_t       gv;
    h  = hash[3:0];
    gu = (h < 4'd8) ? x : y;
    gv = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    gu = h[0] ? -gu : gu;
    gv = h[1] ? -gv : gv;
    return gu + gv;
  endfunction

  // a + floor(t * (b - a) / 2^F)
  function automatic val_t lerp(input fade_t t, input val_t a, input val_t b);
    logic signed [VAL_W:0]             d;
    logic signed [FADE_W:0]            ts;
    logic signed [VAL_W+FADE_W+1:0]    prod;
    d    = {b[VAL_W-1], b} - {a[VAL_W-1], a};
    ts   = {1'b0, t};
    prod = d * ts;
    return a + val_t'(prod >>> FRAC_BITS);
  endfunction

endpackage

`default_nettype wire

### design/pn3d_ram.sv
// ----------------------------------------------------------------------------
// pn3d_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### design/pn3d_if.sv
// ----------------------------------------------------------------------------
// pn3d_if
// Valid/ready channels for noise requests and noise results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pn3d_in_if;
  import pn3d_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [IDX_W-1:0]          table_index;
  logic [IDX_W-1:0]          table_value;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, mode, table_index, table_value, coord_x, coord_y,
                  coord_z, input ready);
  modport sink   (input valid, mode, table_index, table_value, coord_x, coord_y,
                  coord_z, output ready);
endinterface

interface pn3d_out_if;
  import pn3d_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

`default_nettype wire

### design/perlin_noise_3d.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d
// Improved 3D gradient noise, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken. Seven replicated 2-read-port table copies
// serve the 14 lookups of each point.
// Table writes follow a load down the lookup stages, so each point sees the
// table as of its own transfer. Reset clears all valid bits; the table is
// undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module perlin_noise_3d
  import pn3d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  pn3d_in_if.sink     sample,
  pn3d_out_if.source  result
);

  logic en;
  logic acc;
  logic we;

  assign en           = !result.valid || result.ready;
  assign sample.ready = en && !rst;
  assign acc          = sample.valid && sample.ready;
  assign we           = acc && (mode_t'(sample.mode) == MODE_LOAD);

  // stage 0 split
  idx_t  idx0 [AXES];
  frac_t fr0  [AXES];
  always_comb begin
    idx0[0] = sample.coord_x[FRAC_BITS +: IDX_W];
    idx0[1] = sample.coord_y[FRAC_BITS +: IDX_W];
    idx0[2] = sample.coord_z[FRAC_BITS +: IDX_W];
    fr0[0]  = sample.coord_x[FRAC_BITS-1:0];
    fr0[1]  = sample.coord_y[FRAC_BITS-1:0];
    fr0[2]  = sample.coord_z[FRAC_BITS-1:0];
  end

  // pipeline registers
  logic                    v1, v2, v3, v4, v5, v6;
  logic                    we1, we2;
  idx_t                    waddr1, waddr2, wdata1, wdata2;
  idx_t                    idx1 [AXES];
  idx_t                    idx2 [AXES];
  frac_t                   fr1  [AXES];
  frac_t                   fr2  [AXES];
  frac_t                   fr3  [AXES];
  logic [2*FRAC_BITS-1:0]  ff1  [AXES];
  logic [Q_W-1:0]          q2   [AXES];
  logic [Q_W-1:0]          q3   [AXES];
  frac_t                   f2s2 [AXES];
  frac_t                   f3s3 [AXES];
  fade_t                   fade4 [AXES];
  fade_t                   fv5, fw5, fw6;
  val_t                    g4 [CORNERS];
  val_t                    l5 [4];
  val_t                    l6 [2];
  logic signed [OUT_W-1:0] out_value;
  logic                    out_valid;

  // table copies
  idx_t p_x0, p_x1, p_a0, p_a1, p_b0, p_b1;
  idx_t h3 [CORNERS];
  idx_t addr_a, addr_b;
  idx_t addr3 [4];

  assign addr_a = p_x0 + idx1[1];
  assign addr_b = p_x1 + idx1[1];
  always_comb begin
    addr3[0] = p_a0 + idx2[2];
    addr3[1] = p_a1 + idx2[2];
    addr3[2] = p_b0 + idx2[2];
    addr3[3] = p_b1 + idx2[2];
  end

  pn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_x (
    .clk(clk), .we(we), .waddr(sample.table_index), .wdata(sample.table_value),
    .re(en), .raddr_a(idx0[0]), .raddr_b(idx0[0] + idx_t'(1)),
    .rdata_a(p_x0), .rdata_b(p_x1));

  pn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_a (
    .clk(clk), .we(we1 && en), .waddr(waddr1), .wdata(wdata1),
    .re(en), .raddr_a(addr_a), .raddr_b(addr_a + idx_t'(1)),
    .rdata_a(p_a0), .rdata_b(p_a1));

  pn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_b (
    .clk(clk), .we(we1 && en), .waddr(waddr1), .wdata(wdata1),
    .re(en), .raddr_a(addr_b), .raddr_b(addr_b + idx_t'(1)),
    .rdata_a(p_b0), .rdata_b(p_b1));

  // lane k serves corners with (x,y) = (k[1], k[0]); z low and high
  for (genvar k = 0; k < 4; k++) begin : g_ram3
    pn3d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_ram_c (
      .clk(clk), .we(we2 && en), .waddr(waddr2), .wdata(wdata2),
      .re(en), .raddr_a(addr3[k]), .raddr_b(addr3[k] + idx_t'(1)),
      .rdata_a(h3[{1'b0, k[0], k[1]}]), .rdata_b(h3[{1'b1, k[0], k[1]}]));
  end

  // fade: p = 6f^2 - 15fS + 10S^2
  logic [2*FRAC_BITS+5:0] p1 [AXES];
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      p1[a] = ({6'd0, ff1[a]} * 38'd6)
            - ({22'd0, fr1[a]} * 38'd15 << FRAC_BITS)
            + (38'd10 << (2*FRAC_BITS));
    end
  end

  logic [2*FRAC_BITS-1:0] f3p [AXES];
  logic [FRAC_BITS+Q_W-1:0] fdp [AXES];
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      f3p[a] = f2s2[a] * fr2[a];
      fdp[a] = f3s3[a] * q3[a];
    end
  end

  // gradients
  val_t gc [CORNERS];
  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      gc[c] = grad(h3[c],
        c[0] ? val_t'($signed({1'b0, fr3[0]})) - val_t'(1 << FRAC_BITS)
             : val_t'($signed({1'b0, fr3[0]})),
        c[1] ? val_t'($signed({1'b0, fr3[1]})) - val_t'(1 << FRAC_BITS)
             : val_t'($signed({1'b0, fr3[1]})),
        c[2] ? val_t'($signed({1'b0, fr3[2]})) - val_t'(1 << FRAC_BITS)
             : val_t'($signed({1'b0, fr3[2]})));
    end
  end

  val_t fin;
  assign fin = lerp(fw6, l6[0], l6[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      waddr1 <= sample.table_index;
      wdata1 <= sample.table_value;
      waddr2 <= waddr1;
      wdata2 <= wdata1;
      for (int a = 0; a < AXES; a++) begin
        idx1[a]  <= idx0[a];
        fr1[a]   <= fr0[a];
        ff1[a]   <= fr0[a] * fr0[a];
        idx2[a]  <= idx1[a];
        fr2[a]   <= fr1[a];
        q2[a]    <= p1[a][FRAC_BITS +: Q_W];
        f2s2[a]  <= ff1[a][FRAC_BITS +: FRAC_BITS];
        fr3[a]   <= fr2[a];
        q3[a]    <= q2[a];
        f3s3[a]  <= f3p[a][FRAC_BITS +: FRAC_BITS];
        fade4[a] <= fdp[a][FRAC_BITS +: FADE_W];
      end
      for (int c = 0; c < CORNERS; c++) begin
        g4[c] <= gc[c];
      end
      for (int k = 0; k < 4; k++) begin
        l5[k] <= lerp(fade4[0], g4[2*k], g4[2*k+1]);
      end
      fv5   <= fade4[1];
      fw5   <= fade4[2];
      l6[0] <= lerp(fv5, l5[0], l5[1]);
      l6[1] <= lerp(fv5, l5[2], l5[3]);
      fw6   <= fw5;
      if (fin > val_t'(OUT_MAX)) begin
        out_value <= OUT_MAX;
      end else if (fin < val_t'(OUT_MIN)) begin
        out_value <= OUT_MIN;
      end else begin
        out_value <= fin[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      we1 <= 1'b0; we2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= acc && (mode_t'(sample.mode) == MODE_EVAL);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      we1 <= we;
      we2 <= we1;
      out_valid <= v6;
    end
  end

  assign result.valid       = out_valid;
  assign result.noise_value = out_value;

endmodule

`default_nettype wire

### sim/pn3d_checker.sv
// ----------------------------------------------------------------------------
// pn3d_checker
// Watches the request and result channels of the noise block, keeps a shadow
// permutation table, computes the expected noise for every evaluate transfer
// and compares it with each result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module pn3d_checker
  import pn3d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pn3d_in_if        sample,
  pn3d_out_if       result,
  output int        fail_count,
  output int        pending,
  output int        noise_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SCALE = 64'sd1 << FRAC_BITS;

  logic [7:0]              shadow_perm [TABLE_SIZE];
  logic signed [OUT_W-1:0] noise_queue [$];

  function automatic longint fade_curve(input longint f);
    longint p;
    longint q;
    longint f2;
    longint f3;
    p  = 6 * f * f - 15 * f * SCALE + 10 * SCALE * SCALE;
    q  = p >>> FRAC_BITS;
    f2 = (f * f) >>> FRAC_BITS;
    f3 = (f2 * f) >>> FRAC_BITS;
    return (f3 * q) >>> FRAC_BITS;
  endfunction

  function automatic longint blend(input longint t, input longint a, input longint b);
    return a + ((t * (b - a)) >>> FRAC_BITS);
  endfunction

  function automatic longint corner_dot(input int hash, input longint x, input longint y,
                                        input longint z);
    int     h;
    longint gu;
    longint gv;
    h  = hash & 15;
    gu = (h < 8) ? x : y;
    gv = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  function automatic int perm(input int idx);
    return int'(shadow_perm[idx & 255]);
  endfunction

  function automatic logic signed [OUT_W-1:0] noise_at(
    input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
    input logic signed [COORD_W-1:0] cz);
    longint vx, vy, vz, fx, fy, fz, x1, y1, z1, u, v, w, r;
    int     ix, iy, iz, a, aa, ab, b, ba, bb;
    vx = cx; vy = cy; vz = cz;
    ix = int'((vx >>> FRAC_BITS) & 255);
    iy = int'((vy >>> FRAC_BITS) & 255);
    iz = int'((vz >>> FRAC_BITS) & 255);
    fx = vx & (SCALE - 1); fy = vy & (SCALE - 1); fz = vz & (SCALE - 1);
    x1 = fx - SCALE; y1 = fy - SCALE; z1 = fz - SCALE;
    u = fade_curve(fx); v = fade_curve(fy); w = fade_curve(fz);
    a  = perm(ix) + iy;
    aa = perm(a) + iz;
    ab = perm(a + 1) + iz;
    b  = perm(ix + 1) + iy;
    ba = perm(b) + iz;
    bb = perm(b + 1) + iz;
    r = blend(w,
          blend(v,
            blend(u, corner_dot(perm(aa), fx, fy, fz), corner_dot(perm(ba), x1, fy, fz)),
            blend(u, corner_dot(perm(ab), fx, y1, fz), corner_dot(perm(bb), x1, y1, fz))),
          blend(v,
            blend(u, corner_dot(perm(aa + 1), fx, fy, z1),
                  corner_dot(perm(ba + 1), x1, fy, z1)),
            blend(u, corner_dot(perm(ab + 1), fx, y1, z1),
                  corner_dot(perm(bb + 1), x1, y1, z1))));
    r = r >>> (FRAC_BITS - 16);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return OUT_W'(r);
  endfunction

  assign pending = noise_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
      noise_seen <= 0;
      noise_queue.delete();
    end else begin
      if (result.valid && result.ready) begin
        noise_seen <= noise_seen + 1;
        if (noise_queue.size() == 0) begin
          $error("unexpected result transfer: noise_value=%0d", result.noise_value);
          fail_count <= fail_count + 1;
        end else if (result.noise_value !== noise_queue[0]) begin
          $error("noise_value mismatch: expected %0d, actual %0d", noise_queue[0],
                 result.noise_value);
          fail_count <= fail_count + 1;
          void'(noise_queue.pop_front());
        end else begin
          void'(noise_queue.pop_front());
        end
      end
      if (sample.valid && sample.ready) begin
        if (mode_t'(sample.mode) == MODE_LOAD)
          shadow_perm[sample.table_index] = sample.table_value;
        else
          noise_queue.push_back(noise_at(sample.coord_x, sample.coord_y, sample.coord_z));
      end
    end
  end

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 3D gradient noise block: loads the permutation
// table, evaluates directed points, then mixes random table reloads and
// random points with random idle gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import pn3d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   fail_count;
  int   pending;
  int   noise_seen;
  int   evals_sent = 0;
  int   loads_sent = 0;

  pn3d_in_if  sample ();
  pn3d_out_if result ();

  perlin_noise_3d i_dut (.clk(clk), .rst(rst), .sample(sample), .result(result));

  pn3d_checker i_checker (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .fail_count(fail_count), .pending(pending), .noise_seen(noise_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side backpressure
  initial begin
    int g;
    result.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      g = ($urandom_range(0, 9) < 3) ? 0 : gap_length();
      if (g > 0) begin
        result.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send(input mode_t m, input logic [7:0] idx, input logic [7:0] val,
                      input logic [23:0] cx, input logic [23:0] cy,
                      input logic [23:0] cz, input bit gaps);
    int g;
    g = gaps ? gap_length() : 0;
    if (g > 0) begin
      sample.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    sample.valid       <= 1'b1;
    sample.mode        <= m;
    sample.table_index <= idx;
    sample.table_value <= val;
    sample.coord_x     <= cx;
    sample.coord_y     <= cy;
    sample.coord_z     <= cz;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    if (m == MODE_LOAD) loads_sent++;
    else evals_sent++;
  endtask

  task automatic load_table(input int style, input bit gaps);
    int order [256];
    for (int i = 0; i < 256; i++) order[i] = i;
    order.shuffle();
    for (int i = 0; i < 256; i++)
      send(MODE_LOAD, 8'(i), (style == 0) ? 8'(order[i]) :
           (style == 1) ? 8'($urandom) : 8'(255 - i), 24'($urandom), 24'($urandom),
           24'($urandom), gaps);
  endtask

  task automatic eval_point(input logic [23:0] cx, input logic [23:0] cy,
                            input logic [23:0] cz, input bit gaps);
    send(MODE_EVAL, 8'($urandom), 8'($urandom), cx, cy, cz, gaps);
  endtask

  function automatic logic [23:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return {8'($urandom), 16'h0000};
    if (r == 1) return {8'($urandom), 16'hFFFF};
    if (r == 2) return {8'($urandom), 16'h8000};
    return 24'($urandom);
  endfunction

  initial begin
    sample.valid       = 1'b0;
    sample.mode        = MODE_LOAD;
    sample.table_index = '0;
    sample.table_value = '0;
    sample.coord_x     = '0;
    sample.coord_y     = '0;
    sample.coord_z     = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_table(2, 1'b0);
    eval_point(24'h000000, 24'h000000, 24'h000000, 1'b0);
    eval_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    eval_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
    eval_point(24'hFFFFFF, 24'h000001, 24'h00FFFF, 1'b0);
    eval_point(24'h008000, 24'h008000, 24'h008000, 1'b0);
    eval_point(24'h00FFFF, 24'hFF0000, 24'h7F8000, 1'b0);
    eval_point(24'h123456, 24'hABCDEF, 24'h555555, 1'b1);
    eval_point(24'hAAAAAA, 24'h555555, 24'hFFFF00, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      load_table(phase == 1 ? 1 : 0, 1'b1);
      for (int n = 0; n < 224; n++) begin
        if (n == 112) begin
          sample.valid <= 1'b0;
          @(posedge clk iff pending == 0);
        end
        eval_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
      end
    end
    sample.valid <= 1'b0;

    @(posedge clk iff pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d table loads and %0d noise evaluations, %0d results checked",
             loads_sent, evals_sent, noise_seen);
    $display("tb: four table fills, corner and fraction extremes, random stalls");
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
